@@ design/ckpd_pkg.sv @@
// ----------------------------------------------------------------------------
// ckpd_pkg
// Shared types, constants and helpers of the checksummed packet deframer.
// ----------------------------------------------------------------------------
package ckpd_pkg;

   localparam int MAX_BODY_DEFAULT = 8192;
   localparam int BYTE_WIDTH       = 8;
   localparam int LEN_WIDTH        = 14;

   localparam logic [BYTE_WIDTH-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_WIDTH-1:0] CHAR_HASH   = 8'h23;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_BODY = 2'd1,
      PHASE_DIG1 = 2'd2,
      PHASE_DIG2 = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2,
      KIND_DROP = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTE_WIDTH-1:0] body_byte;
      logic [LEN_WIDTH-1:0]  body_length;
   } result_type;

   // Bit 4 set marks a byte that is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [BYTE_WIDTH-1:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

@@ design/ckpd_input_stage.sv @@
// ----------------------------------------------------------------------------
// ckpd_input_stage
// Input register: captures one received byte per transaction.
// ----------------------------------------------------------------------------
module ckpd_input_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ckpd_pkg::BYTE_WIDTH-1:0] req_byte_in,
   input  logic                           advance,
   output logic                           item_valid,
   output logic [ckpd_pkg::BYTE_WIDTH-1:0] item_byte
);
   import ckpd_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [BYTE_WIDTH-1:0] byte_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff <= req_byte_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

@@ design/ckpd_framer.sv @@
// ----------------------------------------------------------------------------
// ckpd_framer
// Framing state machine: tracks phase, checksum and length, builds results.
// ----------------------------------------------------------------------------
module ckpd_framer #(
   parameter int MAX_BODY = ckpd_pkg::MAX_BODY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [ckpd_pkg::BYTE_WIDTH-1:0] item_byte,
   output logic                            result_valid,
   output ckpd_pkg::result_type            result
);
   import ckpd_pkg::*;

   localparam int CountWidth = $clog2(MAX_BODY + 1);
   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_BODY);

   phase_type             phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0] sum_ff, sum_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [BYTE_WIDTH-1:0] digit_ff, digit_in;

   logic [CountWidth+LEN_WIDTH-1:0] count_ext;
   logic [LEN_WIDTH-1:0]            length;
   logic [4:0]                      hi, lo;

   assign count_ext = {{LEN_WIDTH{1'b0}}, count_ff};
   assign length    = count_ext[LEN_WIDTH-1:0];
   assign hi        = hex_value(digit_ff);
   assign lo        = hex_value(item_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         sum_ff   <= '0;
         count_ff <= '0;
         digit_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         digit_ff <= digit_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      digit_in     = digit_ff;
      result_valid = 1'b0;
      result       = '{kind: KIND_BYTE, body_byte: '0, body_length: '0};
      if (step) begin
         unique case (phase_ff)
            PHASE_IDLE: begin
               if (item_byte == CHAR_DOLLAR) begin
                  sum_in   = '0;
                  count_in = '0;
                  phase_in = PHASE_BODY;
               end
            end
            PHASE_BODY: begin
               if (item_byte == CHAR_HASH) begin
                  phase_in = PHASE_DIG1;
               end else if (count_ff == MaxCount) begin
                  result_valid       = 1'b1;
                  result.kind        = KIND_DROP;
                  result.body_length = length;
                  phase_in           = PHASE_IDLE;
                  if (item_byte == CHAR_DOLLAR) begin
                     sum_in   = '0;
                     count_in = '0;
                     phase_in = PHASE_BODY;
                  end
               end else begin
                  sum_in           = sum_ff + item_byte;
                  count_in         = count_ff + 1'b1;
                  result_valid     = 1'b1;
                  result.kind      = KIND_BYTE;
                  result.body_byte = item_byte;
               end
            end
            PHASE_DIG1: begin
               digit_in = item_byte;
               phase_in = PHASE_DIG2;
            end
            PHASE_DIG2: begin
               phase_in           = PHASE_IDLE;
               result_valid       = 1'b1;
               result.body_length = length;
               if (!hi[4] && !lo[4] && {hi[3:0], lo[3:0]} == sum_ff) begin
                  result.kind = KIND_GOOD;
               end else begin
                  result.kind = KIND_BAD;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/ckpd_output_stage.sv @@
// ----------------------------------------------------------------------------
// ckpd_output_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ckpd_output_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  ckpd_pkg::result_type            result,
   output logic                            advance,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [ckpd_pkg::BYTE_WIDTH-1:0] rsp_body_byte,
   output logic [ckpd_pkg::LEN_WIDTH-1:0]  rsp_body_length
);
   import ckpd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = result_ff.kind;
   assign rsp_body_byte   = result_ff.body_byte;
   assign rsp_body_length = result_ff.body_length;

endmodule

@@ design/checksummed_packet_deframer.sv @@
// An accepted byte passes the input register, then any result it gives the result register, on the rsp_ side.
// Throughput: one byte per cycle while no held result stalls the framer; the framing state advances once per byte.
// A held result stalls the input register only when both registers are full.
// Reset: synchronous, active high; clears phase, checksum, count, first digit
// and both register valid flags.
// ----------------------------------------------------------------------------
// checksummed_packet_deframer
// Deframes a '$'-opened, '#'-closed packet stream with a two-digit hex
// checksum; emits body bytes and a good, bad or dropped verdict per packet.
// ----------------------------------------------------------------------------
module checksummed_packet_deframer #(
   parameter int MAX_BODY = ckpd_pkg::MAX_BODY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ckpd_pkg::BYTE_WIDTH-1:0] req_byte_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [ckpd_pkg::BYTE_WIDTH-1:0] rsp_body_byte,
   output logic [ckpd_pkg::LEN_WIDTH-1:0]  rsp_body_length
);
   import ckpd_pkg::*;

   logic                  advance;
   logic                  item_valid;
   logic [BYTE_WIDTH-1:0] item_byte;
   logic                  result_valid;
   result_type            result;

   ckpd_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   ckpd_framer #(
      .MAX_BODY (MAX_BODY)
   ) u_framer (
      .clock        (clock),
      .reset        (reset),
      .step         (item_valid && advance),
      .item_byte    (item_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   ckpd_output_stage u_output (
      .clock           (clock),
      .reset           (reset),
      .load            (result_valid),
      .result          (result),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_body_byte   (rsp_body_byte),
      .rsp_body_length (rsp_body_length)
   );

endmodule
